@@ hdl/brsa_pkg.sv @@
// ----------------------------------------------------------------------------
// brsa_pkg
// Shared widths, constants and record types of the row statistics block.
// ----------------------------------------------------------------------------
package brsa_pkg;

   localparam int ROW_W   = 10;
   localparam int ROWS    = 1 << ROW_W;
   localparam int BIN_W   = 4;
   localparam int BINS    = 1 << BIN_W;
   localparam int HIST_W  = 16;
   localparam int CNT_W   = 32;
   localparam int SUM_W   = 64;
   localparam int BETA_W  = 32;
   localparam int FX_BITS = 31;
   localparam int HALF_W  = HIST_W + BIN_W - 1;   // sum of one histogram half
   localparam int TEST_W  = HALF_W + 5;           // room for 20 * count

   localparam logic [BETA_W-1:0] FX_ONE   = BETA_W'(1) << FX_BITS;
   localparam logic [HIST_W-1:0] HIST_MAX = '1;

   // request kinds carried on tuser
   localparam logic KIND_ADD  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef logic [BINS-1:0][HIST_W-1:0] hist_row_type;

   typedef struct packed {
      logic [BETA_W-1:0] high_min;
      logic [BETA_W-1:0] low_max;
      logic [SUM_W-1:0]  high_sum;
      logic [SUM_W-1:0]  low_sum;
      logic [CNT_W-1:0]  high_count;
      logic [CNT_W-1:0]  low_count;
      logic [SUM_W-1:0]  square_sum;
      logic [SUM_W-1:0]  sum;
      logic [CNT_W-1:0]  count;
   } stat_rec_type;

endpackage

@@ hdl/beta_row_statistics_accumulator.sv @@
// ----------------------------------------------------------------------------
// beta_row_statistics_accumulator
// Per-row beta statistics held in a record memory and a histogram memory.
// ----------------------------------------------------------------------------
//  Channel | Ports           | Contents
//  req     | tdata, tuser    | tdata: row, methylated, unmethylated; tuser: kind
//  rsp     | tdata           | totals, extremes, quantile bins, valid flag
//  csr     | we, wdata       | min_coverage
//
//  An add runs the bit-serial divider, then the multiply and the
//  read-modify-write of both memories. A skipped add writes nothing.
//  A read runs a 16-bin summing walk, then a 16-bin quantile walk.
//  After reset a clearing pass over all 1024 rows runs with req_tready low.
//  A finished result waits in the output register; the next request is taken.
// ----------------------------------------------------------------------------
module beta_row_statistics_accumulator
   import brsa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,   // row[9:0], methylated[41:10], unmethylated[73:42]
   input  logic         req_tuser,   // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // sample_count[31:0], beta_sum[94:32], beta_square_sum[157:95], low_count[189:158],
   // high_count[221:190], low_sum[284:222], high_sum[347:285], low_max[379:348],
   // high_min[411:380], low_q95_bin[415:412], high_q05_bin[419:416],
   // quantiles_valid[420]
   output logic [423:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [31:0]  csr_wdata
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_SQ    = 3'd3;
   localparam logic [2:0] ST_UPD   = 3'd4;
   localparam logic [2:0] ST_SUM   = 3'd5;
   localparam logic [2:0] ST_SCAN  = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   stat_rec_type rec_mem  [ROWS];
   hist_row_type hist_mem [ROWS];

   logic [2:0]       state_ff, state_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [31:0]      min_cov_ff;
   stat_rec_type     rec_rd_ff;
   hist_row_type     hist_rd_ff;
   logic             u_zero_ff, u_zero_in;
   logic             m_lt_u_ff, m_lt_u_in;
   logic             m_eq_u_ff, m_eq_u_in;
   logic [BETA_W-1:0] beta_ff, beta_in;
   logic [BIN_W-1:0] bin_ff, bin_in;
   logic [63:0]      prod_ff;
   logic [BIN_W-1:0] idx_ff, idx_in;
   logic [HALF_W-1:0] lo_n_ff, lo_n_in, hi_n_ff, hi_n_in, cum_ff, cum_in;
   logic [BIN_W-1:0] qlo_ff, qlo_in, qhi_ff, qhi_in;
   logic             lo_hit_ff, lo_hit_in, hi_hit_ff, hi_hit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [423:0]     rsp_data_ff, rsp_data_in;

   logic [ROW_W-1:0] req_row;
   logic [31:0]      req_m, req_u;
   logic [32:0]      total;
   logic             accept, rd_en;
   logic             div_start, div_done;
   logic [31:0]      div_q;
   logic             wr_en;
   logic [ROW_W-1:0] wr_addr;
   stat_rec_type     rec_wr;
   hist_row_type     hist_wr;
   logic [32:0]      sq_term;
   logic [HIST_W-1:0] hv;
   logic [HALF_W-1:0] cum_next;
   logic             qvalid;

   assign req_row = req_tdata[9:0];
   assign req_m   = req_tdata[41:10];
   assign req_u   = req_tdata[73:42];
   assign total   = {1'b0, req_m} + {1'b0, req_u};

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rd_en      = accept;
   assign div_start  = accept && (req_tuser == KIND_ADD) && (total != '0)
                       && (total >= {1'b0, min_cov_ff});

   brsa_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_m),
      .divisor  (total),
      .done     (div_done),
      .quotient (div_q)
   );

   assign sq_term  = 33'((prod_ff + (64'd1 << (FX_BITS - 1))) >> FX_BITS);
   assign hv       = hist_rd_ff[idx_ff];
   assign cum_next = ((idx_ff == BIN_W'(BINS / 2)) ? '0 : cum_ff) + HALF_W'(hv);
   assign qvalid   = (rec_rd_ff.low_count != '0) && (rec_rd_ff.high_count != '0)
                     && (lo_n_ff != '0) && (hi_n_ff != '0);

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      u_zero_in    = u_zero_ff;
      m_lt_u_in    = m_lt_u_ff;
      m_eq_u_in    = m_eq_u_ff;
      beta_in      = beta_ff;
      bin_in       = bin_ff;
      idx_in       = idx_ff;
      lo_n_in      = lo_n_ff;
      hi_n_in      = hi_n_ff;
      cum_in       = cum_ff;
      qlo_in       = qlo_ff;
      qhi_in       = qhi_ff;
      lo_hit_in    = lo_hit_ff;
      hi_hit_in    = hi_hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = row_ff;
      rec_wr       = rec_rd_ff;
      hist_wr      = hist_rd_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            rec_wr  = '0;
            rec_wr.high_min = FX_ONE;
            hist_wr = '0;
            row_in  = row_ff + ROW_W'(1);
            if (row_ff == ROW_W'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               row_in    = req_row;
               u_zero_in = (req_u == '0);
               m_lt_u_in = (req_m < req_u);
               m_eq_u_in = (req_m == req_u);
               if (req_tuser != KIND_ADD) begin
                  state_in = ST_SUM;
                  idx_in   = '0;
                  lo_n_in  = '0;
                  hi_n_in  = '0;
               end else if (div_start) begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (u_zero_ff) begin
                  beta_in = FX_ONE;
                  bin_in  = BIN_W'(BINS - 1);
               end else begin
                  beta_in = BETA_W'(({1'b0, div_q} + 33'd1) >> 1);
                  bin_in  = div_q[31 -: BIN_W];
               end
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            wr_en = 1'b1;
            rec_wr.count      = rec_rd_ff.count + CNT_W'(1);
            rec_wr.sum        = rec_rd_ff.sum + SUM_W'(beta_ff);
            rec_wr.square_sum = rec_rd_ff.square_sum + SUM_W'(sq_term);
            if (!m_eq_u_ff) begin
               if (hist_rd_ff[bin_ff] != HIST_MAX) begin
                  hist_wr[bin_ff] = hist_rd_ff[bin_ff] + HIST_W'(1);
               end
               if (m_lt_u_ff) begin
                  rec_wr.low_count = rec_rd_ff.low_count + CNT_W'(1);
                  rec_wr.low_sum   = rec_rd_ff.low_sum + SUM_W'(beta_ff);
                  if (beta_ff > rec_rd_ff.low_max) begin
                     rec_wr.low_max = beta_ff;
                  end
               end else begin
                  rec_wr.high_count = rec_rd_ff.high_count + CNT_W'(1);
                  rec_wr.high_sum   = rec_rd_ff.high_sum + SUM_W'(beta_ff);
                  if (beta_ff < rec_rd_ff.high_min) begin
                     rec_wr.high_min = beta_ff;
                  end
               end
            end
            state_in = ST_IDLE;
         end
         ST_SUM: begin
            if (idx_ff[BIN_W-1]) begin
               hi_n_in = hi_n_ff + HALF_W'(hv);
            end else begin
               lo_n_in = lo_n_ff + HALF_W'(hv);
            end
            idx_in = idx_ff + BIN_W'(1);
            if (idx_ff == BIN_W'(BINS - 1)) begin
               state_in  = ST_SCAN;
               cum_in    = '0;
               qlo_in    = BIN_W'(BINS / 2 - 1);
               qhi_in    = BIN_W'(BINS / 2);
               lo_hit_in = 1'b0;
               hi_hit_in = 1'b0;
            end
         end
         ST_SCAN: begin
            cum_in = cum_next;
            if (!idx_ff[BIN_W-1]) begin
               if (!lo_hit_ff && (TEST_W'(cum_next) * TEST_W'(20)
                                  >= TEST_W'(lo_n_ff) * TEST_W'(19))) begin
                  qlo_in    = idx_ff;
                  lo_hit_in = 1'b1;
               end
            end else begin
               if (!hi_hit_ff && (TEST_W'(cum_next) * TEST_W'(20)
                                  >= TEST_W'(hi_n_ff))) begin
                  qhi_in    = idx_ff;
                  hi_hit_in = 1'b1;
               end
            end
            idx_in = idx_ff + BIN_W'(1);
            if (idx_ff == BIN_W'(BINS - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, qvalid,
                               qvalid ? qhi_ff : {BIN_W{1'b0}},
                               qvalid ? qlo_ff : {BIN_W{1'b0}},
                               rec_rd_ff.high_min, rec_rd_ff.low_max,
                               rec_rd_ff.high_sum[62:0], rec_rd_ff.low_sum[62:0],
                               rec_rd_ff.high_count, rec_rd_ff.low_count,
                               rec_rd_ff.square_sum[62:0], rec_rd_ff.sum[62:0],
                               rec_rd_ff.count};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rec_mem[wr_addr]  <= rec_wr;
         hist_mem[wr_addr] <= hist_wr;
      end
      if (rd_en) begin
         rec_rd_ff  <= rec_mem[req_row];
         hist_rd_ff <= hist_mem[req_row];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_ff       <= '0;
         min_cov_ff   <= 32'd1;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         if (csr_we) begin
            min_cov_ff <= csr_wdata;
         end
      end
      u_zero_ff   <= u_zero_in;
      m_lt_u_ff   <= m_lt_u_in;
      m_eq_u_ff   <= m_eq_u_in;
      beta_ff     <= beta_in;
      bin_ff      <= bin_in;
      prod_ff     <= 64'(beta_ff) * 64'(beta_ff);
      lo_n_ff     <= lo_n_in;
      hi_n_ff     <= hi_n_in;
      cum_ff      <= cum_in;
      qlo_ff      <= qlo_in;
      qhi_ff      <= qhi_in;
      lo_hit_ff   <= lo_hit_in;
      hi_hit_ff   <= hi_hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ hdl/brsa_divider.sv @@
// ----------------------------------------------------------------------------
// brsa_divider
// Restoring divider: quotient floor(m * 2^32 / t) for m < t, one bit a cycle.
// ----------------------------------------------------------------------------
module brsa_divider
   import brsa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [31:0]       dividend,
   input  logic [32:0]       divisor,
   output logic              done,
   output logic [31:0]       quotient
);

   logic [33:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [32:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] shifted;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[32:0], 1'b0};
      if (start) begin
         rem_in  = {2'b00, dividend};
         quo_in  = '0;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = shifted - {1'b0, den_ff};
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
